// ----- hw/rtl/ows_pkg.sv -----
// ---------------------------------------------------------------------------
// ows_pkg
// Shared types, codes and helpers for the 1-Wire ROM search unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ows_pkg;

   typedef enum logic [1:0] {
      FN_FIRST   = 2'd0,
      FN_NEXT    = 2'd1,
      FN_RESET   = 2'd2,
      FN_TRIPLET = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ACT_BUS_RESET = 2'd0,
      ACT_COMMAND   = 2'd1,
      ACT_TRIPLET   = 2'd2,
      ACT_DONE      = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_RESET  = 2'd1,
      PH_SEARCH = 2'd2
   } phase_type;

   localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;
   // reflected form of x^8 + x^5 + x^4 + 1
   localparam logic [7:0] CRC_POLY       = 8'h8C;
   localparam logic [6:0] FAMILY_LIMIT   = 7'd9;
   localparam logic [6:0] END_POSITION   = 7'd65;

   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      func_type func;
      logic     reset_ok;
      logic     id_bit;
      logic     complement_bit;
      logic     taken_dir;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic        direction;
      logic [7:0]  command_byte;
      logic        found;
      logic [63:0] rom_id;
      logic        is_last_device;
      logic [3:0]  family_discrepancy;
      logic        last;
   } rsp_item_type;

   // up to two result transactions produced by one request
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

   // Dallas CRC-8 of one byte, bit at a time
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] x;
      x = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (x[0]) begin
            x = (x >> 1) ^ CRC_POLY;
         end else begin
            x = x >> 1;
         end
      end
      return x;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ows_core.sv -----
// ---------------------------------------------------------------------------
// ows_core
// Search state and the per-transaction update: direction choice, ROM bit
// capture, byte CRC and end-of-pass decision.
// ---------------------------------------------------------------------------
`default_nettype none

module ows_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire ows_pkg::req_item_type item,
   output ows_pkg::rsp_pair_type      results
);
   import ows_pkg::*;

   logic [6:0]  last_disc_ff,   last_disc_in;
   logic [3:0]  last_fam_ff,    last_fam_in;
   logic        last_dev_ff,    last_dev_in;
   logic [63:0] rom_ff,         rom_in;
   logic [6:0]  bit_pos_ff,     bit_pos_in;
   logic [6:0]  last_zero_ff,   last_zero_in;
   logic [7:0]  crc_ff,         crc_in;
   phase_type   phase_ff,       phase_in;

   logic        fail;
   logic        success;
   logic        want_trip;
   logic        trip_dir;
   logic [5:0]  idx;

   function automatic logic pick_dir(input logic [6:0] n, input logic [6:0] ld,
                                     input logic [63:0] rom);
      logic [5:0] bit_idx;
      bit_idx = n[5:0] - 6'd1;
      if (n < ld) begin
         return rom[bit_idx];
      end
      return (n == ld);
   endfunction

   always_comb begin
      last_disc_in = last_disc_ff;
      last_fam_in  = last_fam_ff;
      last_dev_in  = last_dev_ff;
      rom_in       = rom_ff;
      bit_pos_in   = bit_pos_ff;
      last_zero_in = last_zero_ff;
      crc_in       = crc_ff;
      phase_in     = phase_ff;
      fail         = 1'b0;
      success      = 1'b0;
      want_trip    = 1'b0;
      trip_dir     = 1'b0;
      idx          = bit_pos_ff[5:0] - 6'd1;
      results      = '0;

      case (item.func)
         FN_FIRST, FN_NEXT: begin
            if (item.func == FN_FIRST) begin
               last_disc_in = '0;
               last_dev_in  = 1'b0;
               last_fam_in  = '0;
            end
            bit_pos_in   = 7'd1;
            last_zero_in = '0;
            crc_in       = '0;
            if (last_dev_in) begin
               fail = 1'b1;
            end else begin
               phase_in                     = PH_RESET;
               results.count                = 2'd1;
               results.first.action         = ACT_BUS_RESET;
               results.first.last           = 1'b1;
            end
         end
         FN_RESET: begin
            if (phase_ff == PH_RESET) begin
               if (!item.reset_ok) begin
                  fail = 1'b1;
               end else begin
                  phase_in                   = PH_SEARCH;
                  results.count              = 2'd2;
                  results.first.action       = ACT_COMMAND;
                  results.first.command_byte = SEARCH_ROM_CMD;
                  results.second.action      = ACT_TRIPLET;
                  results.second.direction   = pick_dir(bit_pos_ff, last_disc_ff, rom_ff);
                  results.second.last        = 1'b1;
               end
            end
         end
         FN_TRIPLET: begin
            if (phase_ff == PH_SEARCH) begin
               if (item.id_bit && item.complement_bit) begin
                  fail = 1'b1;
               end else begin
                  if (!item.id_bit && !item.complement_bit && !item.taken_dir) begin
                     last_zero_in = bit_pos_ff;
                     if (bit_pos_ff < FAMILY_LIMIT) begin
                        last_fam_in = bit_pos_ff[3:0];
                     end
                  end
                  rom_in[idx] = item.taken_dir;
                  if (bit_pos_ff[2:0] == 3'd0) begin
                     crc_in = crc8_byte(crc_ff, rom_in[idx[5:3]*8 +: 8]);
                  end
                  bit_pos_in = bit_pos_ff + 7'd1;
                  if (bit_pos_in >= END_POSITION) begin
                     if (crc_in == 8'd0) begin
                        last_disc_in = last_zero_in;
                        if (last_zero_in == 7'd0) begin
                           last_dev_in = 1'b1;
                        end
                     end
                     if (crc_in != 8'd0 || rom_in[7:0] == 8'd0) begin
                        fail = 1'b1;
                     end else begin
                        success = 1'b1;
                     end
                  end else begin
                     want_trip = 1'b1;
                     trip_dir  = pick_dir(bit_pos_in, last_disc_ff, rom_in);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (fail) begin
         last_disc_in = '0;
         last_dev_in  = 1'b0;
         last_fam_in  = '0;
      end
      if (fail || success) begin
         phase_in                     = PH_IDLE;
         results.count                = 2'd1;
         results.first.action         = ACT_DONE;
         results.first.found          = success;
         results.first.rom_id         = success ? rom_in : 64'd0;
         results.first.is_last_device = success & last_dev_in;
         results.first.last           = 1'b1;
      end
      if (want_trip) begin
         results.count           = 2'd1;
         results.first.action    = ACT_TRIPLET;
         results.first.direction = trip_dir;
         results.first.last      = 1'b1;
      end
      results.first.family_discrepancy  = last_fam_in;
      results.second.family_discrepancy = last_fam_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_disc_ff <= '0;
         last_fam_ff  <= '0;
         last_dev_ff  <= 1'b0;
         rom_ff       <= '0;
         bit_pos_ff   <= 7'd1;
         last_zero_ff <= '0;
         crc_ff       <= '0;
         phase_ff     <= PH_IDLE;
      end else if (fire) begin
         last_disc_ff <= last_disc_in;
         last_fam_ff  <= last_fam_in;
         last_dev_ff  <= last_dev_in;
         rom_ff       <= rom_in;
         bit_pos_ff   <= bit_pos_in;
         last_zero_ff <= last_zero_in;
         crc_ff       <= crc_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ows_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// ows_rsp_fifo
// Small result queue: takes up to two results a cycle, hands out one when out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ows_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ows_pkg::rsp_pair_type pair,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ows_pkg::rsp_item_type      out_item
);
   import ows_pkg::*;

   rsp_item_type               mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]       wr_ptr_ff,  wr_ptr_in;
   logic [RSP_PTR_W-1:0]       rd_ptr_ff,  rd_ptr_in;
   logic [RSP_COUNT_W-1:0]     count_ff,   count_in;
   logic [1:0]                 n_push;
   logic                       pop;

   assign n_push    = push ? pair.count : 2'd0;
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= RSP_COUNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_COUNT_W'(n_push) - RSP_COUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= pair.first;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/one_wire_rom_search_unit.sv -----
// ---------------------------------------------------------------------------
// one_wire_rom_search_unit
// 1-Wire ROM enumeration engine: start, reset and triplet transactions in,
// bus actions and search results out.
// ---------------------------------------------------------------------------
// Accepts one request transaction per cycle while the result queue has
// room. A request is captured in an input register and processed from
// there against the search state; its results (one, or two for a good
// reset outcome) enter a four-entry result queue that feeds the rsp_
// channel. Processing waits only while the queue has fewer than two free
// entries. The rsp_ channel hands out one result per cycle, so with
// rsp_tready held high requests flow every cycle as long as results do not
// outrun it; the extra result of a good reset outcome is soaked up by the
// queue, and a normal search pass runs without a stall. Out-of-order reset
// or triplet outcomes produce no result.
`default_nettype none

module one_wire_rom_search_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] reset_ok, [1] id_bit, [2] complement_bit, [3] taken_dir, [7:4] zero
   input  wire logic [7:0]  req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] direction, [8:1] command_byte, [9] found, [73:10] rom_id,
   // [74] is_last_device, [78:75] family_discrepancy, [79] zero
   output logic [79:0]      rsp_tdata,
   // [1:0] action
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import ows_pkg::*;

   logic          in_vld_ff;
   req_item_type  in_item_ff;
   logic          fire;
   logic          room;
   rsp_pair_type  results;
   rsp_item_type  out_item;

   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func           <= func_type'(req_tuser);
         in_item_ff.reset_ok       <= req_tdata[0];
         in_item_ff.id_bit         <= req_tdata[1];
         in_item_ff.complement_bit <= req_tdata[2];
         in_item_ff.taken_dir      <= req_tdata[3];
      end
   end

   ows_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_item_ff),
      .results (results)
   );

   ows_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .pair      (results),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {1'b0,
                       out_item.family_discrepancy,
                       out_item.is_last_device,
                       out_item.rom_id,
                       out_item.found,
                       out_item.command_byte,
                       out_item.direction};
   assign rsp_tuser = out_item.action;
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1-Wire ROM search unit. A small bus of
// simulated devices with sealed ROM codes answers each search pass, with
// failed resets, missing devices, bad codes, restarts and stray outcomes
// mixed in. Every result transaction is checked against an in-bench model
// of the search state, with random stalls on both streams.
// ---------------------------------------------------------------------------

module tb_top;
   import ows_pkg::*;

   localparam int SEARCH_ITEMS = 1400;
   localparam int STALL_LIMIT  = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;  // [0] reset_ok, [1] id_bit, [2] complement_bit, [3] taken_dir
   logic [1:0]  req_tuser  = '0;  // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] direction, [8:1] command_byte, [9] found, [73:10] rom_id,
   // [74] is_last_device, [78:75] family_discrepancy
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;        // [1:0] action
   logic        rsp_tlast;

   one_wire_rom_search_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // search state as the bench sees it
   logic [6:0]  srch_last_disc   = 7'd0;
   logic [3:0]  srch_family_disc = 4'd0;
   logic        srch_last_dev    = 1'b0;
   logic [63:0] srch_rom         = 64'd0;
   logic [6:0]  srch_bit_pos     = 7'd1;
   logic [6:0]  srch_zero_pos    = 7'd0;
   logic [7:0]  srch_crc         = 8'd0;
   phase_type   srch_phase       = PH_IDLE;

   req_item_type req_backlog[$];
   rsp_item_type awaited_rsp[$];
   logic [63:0]  bus_devices[$];

   int req_queued    = 0;
   int req_accepted  = 0;
   int search_items  = 0;
   int ignored_total = 0;
   int rsp_total     = 0;
   int found_total   = 0;
   int miss_total    = 0;
   int fault_count   = 0;
   int calm_left     = 0;
   int req_gap       = 0;
   int rsp_stall     = 0;
   int idle_cycles   = 0;

   // Dallas CRC-8, one bit at a time, LSB first
   function automatic logic [7:0] dallas_crc_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r  = {1'b0, r[7:1]};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] seal_rom(input logic [55:0] body);
      logic [7:0] crc;
      crc = 8'd0;
      for (int b = 0; b < 7; b++) begin
         crc = dallas_crc_step(crc, body[8*b +: 8]);
      end
      return {crc, body};
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------- search model ----------------

   function automatic logic preferred_direction();
      if (srch_bit_pos < srch_last_disc) begin
         return srch_rom[srch_bit_pos - 7'd1];
      end
      return srch_bit_pos == srch_last_disc;
   endfunction

   task automatic emit_action(input action_type act, input logic dir, input logic [7:0] cmd,
                              input logic found, input logic [63:0] rom, input logic last_dev,
                              input logic last);
      rsp_item_type r;
      r.action             = act;
      r.direction          = dir;
      r.command_byte       = cmd;
      r.found              = found;
      r.rom_id             = rom;
      r.is_last_device     = last_dev;
      r.family_discrepancy = srch_family_disc;
      r.last               = last;
      awaited_rsp.push_back(r);
   endtask

   task automatic forget_search();
      srch_last_disc   = 7'd0;
      srch_last_dev    = 1'b0;
      srch_family_disc = 4'd0;
   endtask

   task automatic end_search(input logic ok);
      srch_phase = PH_IDLE;
      if (!ok || srch_rom[7:0] == 8'd0) begin
         forget_search();
         emit_action(ACT_DONE, 1'b0, 8'd0, 1'b0, 64'd0, 1'b0, 1'b1);
      end else begin
         emit_action(ACT_DONE, 1'b0, 8'd0, 1'b1, srch_rom, srch_last_dev, 1'b1);
      end
   endtask

   task automatic apply_search_transaction(input req_item_type it);
      logic [5:0] bit_idx;
      case (it.func)
         FN_FIRST, FN_NEXT: begin
            if (it.func == FN_FIRST) begin
               forget_search();
            end
            srch_bit_pos  = 7'd1;
            srch_zero_pos = 7'd0;
            srch_crc      = 8'd0;
            if (srch_last_dev) begin
               end_search(1'b0);
            end else begin
               srch_phase = PH_RESET;
               emit_action(ACT_BUS_RESET, 1'b0, 8'd0, 1'b0, 64'd0, 1'b0, 1'b1);
            end
         end
         FN_RESET: begin
            if (srch_phase != PH_RESET) begin
               ignored_total++;
            end else if (!it.reset_ok) begin
               end_search(1'b0);
            end else begin
               srch_phase = PH_SEARCH;
               emit_action(ACT_COMMAND, 1'b0, SEARCH_ROM_CMD, 1'b0, 64'd0, 1'b0, 1'b0);
               emit_action(ACT_TRIPLET, preferred_direction(), 8'd0, 1'b0, 64'd0, 1'b0, 1'b1);
            end
         end
         FN_TRIPLET: begin
            if (srch_phase != PH_SEARCH) begin
               ignored_total++;
            end else if (it.id_bit && it.complement_bit) begin
               end_search(1'b0);  // nobody answered
            end else begin
               if (!it.id_bit && !it.complement_bit && !it.taken_dir) begin
                  srch_zero_pos = srch_bit_pos;
                  if (srch_bit_pos < FAMILY_LIMIT) begin
                     srch_family_disc = srch_bit_pos[3:0];
                  end
               end
               bit_idx = 6'(srch_bit_pos - 7'd1);
               srch_rom[bit_idx] = it.taken_dir;
               if (srch_bit_pos[2:0] == 3'd0) begin
                  srch_crc = dallas_crc_step(srch_crc, srch_rom[{bit_idx[5:3], 3'd0} +: 8]);
               end
               srch_bit_pos = srch_bit_pos + 7'd1;
               if (srch_bit_pos >= END_POSITION) begin
                  if (srch_crc == 8'd0) begin
                     srch_last_disc = srch_zero_pos;
                     if (srch_zero_pos == 7'd0) begin
                        srch_last_dev = 1'b1;
                     end
                  end
                  end_search(srch_crc == 8'd0);
               end else begin
                  emit_action(ACT_TRIPLET, preferred_direction(), 8'd0, 1'b0, 64'd0, 1'b0, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endtask

   // ---------------- stimulus generation ----------------

   task automatic queue_req(input func_type f, input bit rok, input bit id, input bit cmp,
                            input bit dir);
      req_item_type it;
      it.func           = f;
      it.reset_ok       = rok;
      it.id_bit         = id;
      it.complement_bit = cmp;
      it.taken_dir      = dir;
      req_backlog.push_back(it);
      req_queued++;
   endtask

   task automatic refresh_bus(input int count);
      logic [55:0] base;
      logic [55:0] body;
      int          style;
      int          flip_at;
      bus_devices.delete();
      base  = 56'({$urandom, $urandom});
      style = $urandom_range(0, 2);
      for (int k = 0; k < count; k++) begin
         body    = base;
         flip_at = $urandom_range(0, 55);
         case (style)
            0: body = 56'({$urandom, $urandom});
            1: body[8*$urandom_range(0, 6) +: 8] = 8'($urandom);
            default: body[flip_at] = ~body[flip_at];
         endcase
         if (body[7:0] == 8'd0) begin
            body[7:0] = 8'h01;
         end
         if ($urandom_range(0, 9) == 0) begin
            body[7:0] = 8'd0;  // family code of zero, CRC still good
         end
         bus_devices.push_back(seal_rom(body));
      end
   endtask

   // one search pass against the simulated bus; clean passes run straight through
   task automatic queue_search_pass(input bit clean);
      logic [63:0] live[$];
      logic [63:0] kept[$];
      logic [63:0] target;
      bit          has0;
      bit          has1;
      int          abort_at;
      int          abort_kind;
      int          flip_at;
      queue_req((clean || $urandom_range(0, 9) < 7) ? FN_FIRST : FN_NEXT,
                coin(), coin(), coin(), coin());
      search_items++;
      if (!clean && $urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 3)) queue_req(FN_TRIPLET, coin(), coin(), coin(), coin());
      end
      if (!clean && $urandom_range(0, 11) == 0) begin
         queue_req(FN_RESET, 1'b0, coin(), coin(), coin());
         search_items++;
         return;
      end
      queue_req(FN_RESET, 1'b1, coin(), coin(), coin());
      search_items++;
      live   = bus_devices;
      target = live[$urandom_range(0, live.size() - 1)];
      if (!clean && $urandom_range(0, 9) == 0) begin
         flip_at         = $urandom_range(0, 63);
         target[flip_at] = ~target[flip_at];
         live.push_back(target);
      end
      abort_at   = (!clean && $urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : 64;
      abort_kind = $urandom_range(0, 2);
      for (int i = 0; i < 64; i++) begin
         if (i == abort_at) begin
            if (abort_kind == 0) begin
               queue_req(FN_TRIPLET, coin(), 1'b1, 1'b1, coin());
               search_items++;
               return;
            end else if (abort_kind == 1) begin
               queue_req(coin() ? FN_FIRST : FN_NEXT, coin(), coin(), coin(), coin());
               search_items++;
               return;
            end
            queue_req(FN_RESET, coin(), coin(), coin(), coin());  // stray, ignored
         end
         has0 = 1'b0;
         has1 = 1'b0;
         foreach (live[j]) begin
            if (live[j][i]) has1 = 1'b1;
            else has0 = 1'b1;
         end
         queue_req(FN_TRIPLET, coin(), !has0, !has1, target[i]);
         search_items++;
         kept.delete();
         foreach (live[j]) begin
            if (live[j][i] == target[i]) kept.push_back(live[j]);
         end
         live = kept;
      end
   endtask

   task automatic drain_results();
      while (req_accepted != req_queued || awaited_rsp.size() != 0) @(negedge clock);
   endtask

   // ---------------- drivers and checkers ----------------

   // shared spells in which neither stream draws a new random stall
   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 399) == 0) begin
         calm_left <= $urandom_range(100, 300);
      end
   end

   always @(posedge clock) begin : req_driver
      req_item_type got;
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            got.func           = func_type'(req_tuser);
            got.reset_ok       = req_tdata[0];
            got.id_bit         = req_tdata[1];
            got.complement_bit = req_tdata[2];
            got.taken_dir      = req_tdata[3];
            apply_search_transaction(got);
            req_accepted <= req_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_tdata  <= {4'd0, nxt.taken_dir, nxt.complement_bit, nxt.id_bit,
                              nxt.reset_ok};
               req_tuser  <= nxt.func;
               req_tvalid <= 1'b1;
               req_gap    <= (calm_left > 0) ? 0 : random_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
      if (seen !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_total++;
            if (awaited_rsp.size() == 0) begin
               $error("result transaction with nothing awaited: action %0d", rsp_tuser);
               fault_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("action", 64'(want.action), 64'(rsp_tuser));
               check_field("direction", 64'(want.direction), 64'(rsp_tdata[0]));
               check_field("command_byte", 64'(want.command_byte), 64'(rsp_tdata[8:1]));
               check_field("found", 64'(want.found), 64'(rsp_tdata[9]));
               check_field("rom_id", want.rom_id, rsp_tdata[73:10]);
               check_field("is_last_device", 64'(want.is_last_device), 64'(rsp_tdata[74]));
               check_field("family_discrepancy", 64'(want.family_discrepancy),
                           64'(rsp_tdata[78:75]));
               check_field("last", 64'(want.last), 64'(rsp_tlast));
               if (want.action == ACT_DONE) begin
                  if (want.found) found_total++;
                  else miss_total++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left == 0 && $urandom_range(0, 3) == 0) begin
               rsp_stall <= random_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int pass_no;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: out-of-order outcomes, failed reset, each triplet kind, restarts
      queue_req(FN_RESET, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(FN_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(FN_FIRST, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(FN_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_RESET, 1'b0, 1'b1, 1'b1, 1'b1);
      queue_req(FN_NEXT, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_RESET, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(FN_RESET, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(FN_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_TRIPLET, 1'b0, 1'b1, 1'b0, 1'b1);
      queue_req(FN_TRIPLET, 1'b1, 1'b0, 1'b1, 1'b0);
      queue_req(FN_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1);
      queue_req(FN_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b0);
      queue_req(FN_FIRST, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_RESET, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(FN_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_NEXT, 1'b1, 1'b0, 1'b1, 1'b0);
      queue_req(FN_RESET, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(FN_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1);

      // lone device: a full pass, then a next search that ends at once unless the family code was zero
      refresh_bus(1);
      queue_search_pass(1'b1);
      queue_req(FN_NEXT, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(FN_RESET, 1'b1, 1'b0, 1'b0, 1'b0);

      pass_no = 0;
      while (search_items < SEARCH_ITEMS) begin
         if (pass_no % 4 == 0) begin
            refresh_bus($urandom_range(1, 4));
         end
         if (pass_no == 3 || $urandom_range(0, 7) == 0) begin
            drain_results();
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               queue_req(func_type'($urandom_range(0, 3)), coin(), coin(), coin(), coin());
            end
         end
         queue_search_pass(1'b0);
         pass_no++;
      end

      drain_results();
      repeat (32) @(posedge clock);
      $display("%0d request transactions sent (%0d ignored), %0d result transactions checked",
               req_accepted, ignored_total, rsp_total);
      $display("%0d searches identified a device, %0d ended without one",
               found_total, miss_total);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- one_wire_rom_search_unit.f -----
hw/rtl/ows_pkg.sv
hw/rtl/ows_core.sv
hw/rtl/ows_rsp_fifo.sv
hw/rtl/one_wire_rom_search_unit.sv
tb/tb_top.sv
